// ===== sv/id3p_pkg.sv =====
// shared types, constants and helper functions for the id3v2 text frame parser
`default_nettype none

package id3p_pkg;

    // parser phases, one-hot coded
    typedef enum logic [5:0] {
        PH_ID      = 6'b000001,
        PH_SKIP    = 6'b000010,
        PH_SIZE    = 6'b000100,
        PH_FHDR    = 6'b001000,
        PH_PAYLOAD = 6'b010000,
        PH_DONE    = 6'b100000
    } phase_t;

    typedef logic [1:0] kind_t;
    typedef logic [2:0] field_t;

    // result kinds
    localparam kind_t KIND_TEXT      = 2'd0;
    localparam kind_t KIND_FIELD_END = 2'd1;
    localparam kind_t KIND_TAG_DONE  = 2'd2;
    localparam kind_t KIND_NO_HEADER = 2'd3;

    // text fields
    localparam field_t FIELD_TITLE    = 3'd0;
    localparam field_t FIELD_ARTIST   = 3'd1;
    localparam field_t FIELD_ALBUM    = 3'd2;
    localparam field_t FIELD_YEAR     = 3'd3;
    localparam field_t FIELD_GENRE    = 3'd4;
    localparam field_t FIELD_COMPOSER = 3'd5;
    localparam field_t NO_FIELD       = 3'd6;

    localparam logic [7:0] SYNCSAFE_MASK = 8'h7f;

    // byte counts of the fixed header parts
    localparam logic [3:0] MARKER_BYTES    = 4'd3;
    localparam logic [3:0] SKIP_BYTES      = 4'd3;
    localparam logic [3:0] SIZE_BYTES      = 4'd4;
    localparam logic [3:0] FRAME_ID_BYTES  = 4'd4;
    localparam logic [3:0] FRAME_LEN_END   = 4'd8;
    localparam logic [3:0] FRAME_HDR_BYTES = 4'd10;

    // frame ids of the text frames
    localparam logic [31:0] ID_TIT2 = 32'h5449_5432;
    localparam logic [31:0] ID_TPE1 = 32'h5450_4531;
    localparam logic [31:0] ID_TALB = 32'h5441_4c42;
    localparam logic [31:0] ID_TYER = 32'h5459_4552;
    localparam logic [31:0] ID_TCON = 32'h5443_4f4e;
    localparam logic [31:0] ID_TCOM = 32'h5443_4f4d;

    // one result request
    typedef struct packed {
        kind_t      kind;
        field_t     field;
        logic [7:0] text_byte;
        logic       last;
    } result_t;

    // expected byte of the "ID3" marker at a given position
    function automatic logic [7:0] marker_byte(input logic [1:0] pos);
        logic [7:0] value;
        unique case (pos)
            2'd0:    value = 8'h49;
            2'd1:    value = 8'h44;
            2'd2:    value = 8'h33;
            default: value = 8'h00;
        endcase
        return value;
    endfunction

    // map a frame id to its text field, or none
    function automatic field_t match_field(input logic [31:0] id);
        field_t fld;
        fld = NO_FIELD;
        if (id == ID_TIT2) fld = FIELD_TITLE;
        if (id == ID_TPE1) fld = FIELD_ARTIST;
        if (id == ID_TALB) fld = FIELD_ALBUM;
        if (id == ID_TYER) fld = FIELD_YEAR;
        if (id == ID_TCON) fld = FIELD_GENRE;
        if (id == ID_TCOM) fld = FIELD_COMPOSER;
        return fld;
    endfunction

endpackage

`default_nettype wire

// ===== sv/id3p_byte_if.sv =====
// byte stream channel: file bytes with a start of file mark
`default_nettype none

interface id3p_byte_if;
    logic       valid;
    logic       ready;
    logic       start_of_file;
    logic [7:0] data_byte;

    modport source (output valid, output start_of_file, output data_byte, input ready);
    modport sink   (input valid, input start_of_file, input data_byte, output ready);
endinterface

`default_nettype wire

// ===== sv/id3p_text_if.sv =====
// text result channel: text bytes and field and tag events
`default_nettype none

interface id3p_text_if;
    import id3p_pkg::*;

    logic       valid;
    logic       ready;
    kind_t      kind;
    field_t     field;
    logic [7:0] text_byte;
    logic       last;

    modport source (output valid, output kind, output field, output text_byte,
                    output last, input ready);
    modport sink   (input valid, input kind, input field, input text_byte,
                    input last, output ready);
endinterface

`default_nettype wire

// ===== sv/id3v2_text_frame_parser_core.sv =====
// id3v2 tag parser top level: walks the tag header and frames, emits text of six text frames
//
// Takes one file byte per cycle on byte_stream and gives at most one result per byte on
// text_stream. Each accepted byte updates the parser state in the same cycle, and its
// result (if any) sits in the output register from the next cycle on. byte_stream.ready
// drops only while a result waits in the output register and text_stream.ready is low;
// any byte stalls then, even one that would cause no result. start_of_file restarts the
// parser on that byte. Results: text bytes of title, artist, album, year, genre and
// composer frames, a field end mark at a zero byte or on an empty frame, tag done, or a
// missing ID3 header. After tag done or a missing header, bytes are taken and dropped
// until the next file.
`default_nettype none

module id3v2_text_frame_parser_core (
    input  wire           clk,
    input  wire           rst_n,
    id3p_byte_if.sink     byte_stream,
    id3p_text_if.source   text_stream
);
    import id3p_pkg::*;

    // parser state
    phase_t        phase_reg,          phase_next;
    logic [3:0]    count_reg,          count_next;
    logic [27:0]   tag_length_reg,     tag_length_next;
    logic [33:0]   consumed_reg,       consumed_next;
    logic [31:0]   frame_id_reg,       frame_id_next;
    logic [31:0]   frame_length_reg,   frame_length_next;
    logic [31:0]   remaining_reg,      remaining_next;
    field_t        selected_reg,       selected_next;
    logic          text_ended_reg,     text_ended_next;

    // output register
    logic          out_valid_reg,      out_valid_next;
    result_t       out_data_reg;

    // values seen by this byte, after an optional restart
    phase_t        cur_phase;
    logic [3:0]    cur_count;
    logic [27:0]   cur_tag_length;
    logic [33:0]   cur_consumed;
    logic [31:0]   cur_frame_id;
    logic [31:0]   cur_frame_length;
    logic [31:0]   cur_remaining;
    field_t        cur_selected;
    logic          cur_text_ended;

    logic          accept;
    logic          res_valid;
    result_t       res;
    logic [7:0]    b;
    logic [3:0]    count_inc;
    field_t        hdr_field;
    logic          frame_end;

    assign b      = byte_stream.data_byte;
    assign accept = byte_stream.valid && byte_stream.ready;

    // take a new byte unless a result is held and stalled
    assign byte_stream.ready = !out_valid_reg || text_stream.ready;

    // restart view of the state
    always_comb
    begin
        if (byte_stream.start_of_file)
        begin
            cur_phase        = PH_ID;
            cur_count        = '0;
            cur_tag_length   = '0;
            cur_consumed     = '0;
            cur_frame_id     = '0;
            cur_frame_length = '0;
            cur_remaining    = '0;
            cur_selected     = NO_FIELD;
            cur_text_ended   = 1'b0;
        end
        else
        begin
            cur_phase        = phase_reg;
            cur_count        = count_reg;
            cur_tag_length   = tag_length_reg;
            cur_consumed     = consumed_reg;
            cur_frame_id     = frame_id_reg;
            cur_frame_length = frame_length_reg;
            cur_remaining    = remaining_reg;
            cur_selected     = selected_reg;
            cur_text_ended   = text_ended_reg;
        end
    end

    assign count_inc = cur_count + 4'd1;
    assign hdr_field = match_field(cur_frame_id);
    assign frame_end = (cur_remaining == 32'd1);

    // per-byte parser step
    always_comb
    begin
        phase_next        = phase_reg;
        count_next        = count_reg;
        tag_length_next   = tag_length_reg;
        consumed_next     = consumed_reg;
        frame_id_next     = frame_id_reg;
        frame_length_next = frame_length_reg;
        remaining_next    = remaining_reg;
        selected_next     = selected_reg;
        text_ended_next   = text_ended_reg;
        res_valid         = 1'b0;
        res               = '0;

        if (accept)
        begin
            phase_next        = cur_phase;
            count_next        = cur_count;
            tag_length_next   = cur_tag_length;
            consumed_next     = cur_consumed;
            frame_id_next     = cur_frame_id;
            frame_length_next = cur_frame_length;
            remaining_next    = cur_remaining;
            selected_next     = cur_selected;
            text_ended_next   = cur_text_ended;

            unique case (cur_phase)
                // "ID3" marker check
                PH_ID:
                begin
                    if (b != marker_byte(cur_count[1:0]))
                    begin
                        phase_next = PH_DONE;
                        res_valid  = 1'b1;
                        res.kind   = KIND_NO_HEADER;
                    end
                    else if (count_inc >= MARKER_BYTES)
                    begin
                        phase_next = PH_SKIP;
                        count_next = '0;
                    end
                    else
                    begin
                        count_next = count_inc;
                    end
                end

                // version and flag bytes
                PH_SKIP:
                begin
                    if (count_inc >= SKIP_BYTES)
                    begin
                        phase_next = PH_SIZE;
                        count_next = '0;
                    end
                    else
                    begin
                        count_next = count_inc;
                    end
                end

                // syncsafe tag size
                PH_SIZE:
                begin
                    tag_length_next = {cur_tag_length[20:0], b[6:0] & SYNCSAFE_MASK[6:0]};
                    if (count_inc >= SIZE_BYTES)
                    begin
                        phase_next    = PH_FHDR;
                        count_next    = '0;
                        consumed_next = '0;
                    end
                    else
                    begin
                        count_next = count_inc;
                    end
                end

                // frame header bytes
                PH_FHDR:
                begin
                    if (cur_count == 4'd0 &&
                        (cur_consumed >= {6'd0, cur_tag_length} || b == 8'd0))
                    begin
                        phase_next = PH_DONE;
                        res_valid  = 1'b1;
                        res.kind   = KIND_TAG_DONE;
                    end
                    else
                    begin
                        if (cur_count < FRAME_ID_BYTES)
                            frame_id_next = {cur_frame_id[23:0], b};
                        else if (cur_count < FRAME_LEN_END)
                            frame_length_next = {cur_frame_length[23:0], b};

                        if (count_inc >= FRAME_HDR_BYTES)
                        begin
                            selected_next   = hdr_field;
                            text_ended_next = 1'b0;
                            remaining_next  = cur_frame_length;
                            consumed_next   = cur_consumed + {30'd0, FRAME_HDR_BYTES}
                                              + {2'd0, cur_frame_length};
                            count_next      = '0;
                            if (cur_frame_length == 32'd0)
                            begin
                                phase_next = PH_FHDR;
                                if (hdr_field < NO_FIELD)
                                begin
                                    res_valid = 1'b1;
                                    res.kind  = KIND_FIELD_END;
                                    res.field = hdr_field;
                                end
                            end
                            else
                            begin
                                phase_next = PH_PAYLOAD;
                            end
                        end
                        else
                        begin
                            count_next = count_inc;
                        end
                    end
                end

                // frame payload: encoding byte, then text
                PH_PAYLOAD:
                begin
                    remaining_next = cur_remaining - 32'd1;
                    count_next     = 4'd1;
                    if (cur_selected < NO_FIELD && !cur_text_ended)
                    begin
                        if (cur_count == 4'd0)
                        begin
                            if (frame_end)
                            begin
                                text_ended_next = 1'b1;
                                res_valid       = 1'b1;
                                res.kind        = KIND_FIELD_END;
                                res.field       = cur_selected;
                            end
                        end
                        else if (b == 8'd0)
                        begin
                            text_ended_next = 1'b1;
                            res_valid       = 1'b1;
                            res.kind        = KIND_FIELD_END;
                            res.field       = cur_selected;
                        end
                        else
                        begin
                            res_valid     = 1'b1;
                            res.kind      = KIND_TEXT;
                            res.field     = cur_selected;
                            res.text_byte = b;
                            res.last      = frame_end;
                        end
                    end
                    if (frame_end)
                    begin
                        phase_next = PH_FHDR;
                        count_next = '0;
                    end
                end

                PH_DONE:
                begin
                    phase_next = PH_DONE;
                end

                default:
                begin
                    phase_next = PH_DONE;
                end
            endcase
        end
    end

    // output register handshake
    always_comb
    begin
        if (accept && res_valid)
            out_valid_next = 1'b1;
        else if (text_stream.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_ID;
            count_reg        <= '0;
            tag_length_reg   <= '0;
            consumed_reg     <= '0;
            frame_id_reg     <= '0;
            frame_length_reg <= '0;
            remaining_reg    <= '0;
            selected_reg     <= NO_FIELD;
            text_ended_reg   <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            phase_reg        <= phase_next;
            count_reg        <= count_next;
            tag_length_reg   <= tag_length_next;
            consumed_reg     <= consumed_next;
            frame_id_reg     <= frame_id_next;
            frame_length_reg <= frame_length_next;
            remaining_reg    <= remaining_next;
            selected_reg     <= selected_next;
            text_ended_reg   <= text_ended_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // result payload register
    always_ff @(posedge clk)
    begin
        if (accept && res_valid)
            out_data_reg <= res;
    end

    assign text_stream.valid     = out_valid_reg;
    assign text_stream.kind      = out_data_reg.kind;
    assign text_stream.field     = out_data_reg.field;
    assign text_stream.text_byte = out_data_reg.text_byte;
    assign text_stream.last      = out_data_reg.last;

    // a tag done or missing header request leaves the parser finished
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && res_valid &&
         (res.kind == KIND_TAG_DONE || res.kind == KIND_NO_HEADER))
        |=> phase_reg == PH_DONE)
    else $error("parser not finished after tag end request");

    // payload walk never runs with nothing left
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_PAYLOAD |-> remaining_reg != 32'd0)
    else $error("payload phase with zero bytes remaining");

    // last flag only marks text bytes
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.last) |-> out_data_reg.kind == KIND_TEXT)
    else $error("last flag on a non-text request");

    // a result cannot be overwritten while stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !text_stream.ready) |-> !accept)
    else $error("byte accepted while result stalled");

endmodule

`default_nettype wire

// ===== bench/tb_id3v2_text_frame_parser_core.sv =====
// self-checking bench for the id3v2 text frame parser: directed byte table, then random tag files
`timescale 1ns / 1ps

module tb_id3v2_text_frame_parser_core;
    import id3p_pkg::*;

    localparam int QUIET_LIMIT  = 2000;
    localparam int RANDOM_ITEMS = 1800;
    localparam logic [23:0] ID3_MARK = 24'h49_44_33;

    // one row of the directed table
    typedef struct {
        bit         sof;
        logic [7:0] data;
        bit         typed;
        bit         typed_has;
        result_t    typed_res;
    } table_row_t;

    logic clk;
    logic rst_n;

    id3p_byte_if byte_if ();
    id3p_text_if text_if ();

    id3v2_text_frame_parser_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_stream (byte_if),
        .text_stream (text_if)
    );

    // idle rates in percent, changed by the stimulus process
    int send_idle_pct = 19;
    int recv_idle_pct = 61;

    // typed expectation that travels with the byte on the wire
    bit      cur_typed;
    bit      cur_typed_has;
    result_t cur_typed_res;

    // parser state mirror
    phase_t      cur_phase;
    logic [3:0]  step_cnt;
    logic [27:0] tag_len_bytes;
    logic [33:0] used_bytes;
    logic [31:0] id_window;
    logic [31:0] frame_len_bytes;
    logic [31:0] payload_left;
    field_t      cur_field;
    logic        text_done;

    result_t     owed_results[$];
    table_row_t  byte_table[$];
    logic [7:0]  file_bytes[$];

    int mismatches = 0;
    int quiet_cycles = 0;
    int files_sent = 0;
    int bytes_sent = 0;
    int table_bytes = 0;
    int kind_seen[4] = '{0, 0, 0, 0};

    // clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    task automatic flag_error(input string msg);
        mismatches++;
        $display("mismatch at %0t ns: %s", $time, msg);
    endtask

    function automatic result_t tag_event(input kind_t k);
        result_t r;
        r = '0;
        r.kind = k;
        return r;
    endfunction

    function automatic field_t text_field_of(input logic [31:0] id);
        field_t f;
        case (id)
            ID_TIT2: f = FIELD_TITLE;
            ID_TPE1: f = FIELD_ARTIST;
            ID_TALB: f = FIELD_ALBUM;
            ID_TYER: f = FIELD_YEAR;
            ID_TCON: f = FIELD_GENRE;
            ID_TCOM: f = FIELD_COMPOSER;
            default: f = NO_FIELD;
        endcase
        return f;
    endfunction

    function automatic void restart_parser();
        cur_phase       = PH_ID;
        step_cnt        = '0;
        tag_len_bytes   = '0;
        used_bytes      = '0;
        id_window       = '0;
        frame_len_bytes = '0;
        payload_left    = '0;
        cur_field       = NO_FIELD;
        text_done       = 1'b0;
    endfunction

    // advance the mirror by one file byte, returns 1 when a result is due
    function automatic bit parse_byte(input bit sof, input logic [7:0] b, output result_t r);
        bit has;
        bit enc;
        int idx;
        has = 1'b0;
        r = '0;
        if (sof)
            restart_parser();
        case (cur_phase)
            PH_ID:
            begin
                idx = 2 - int'(step_cnt);
                if (b != ID3_MARK[8 * idx +: 8])
                begin
                    cur_phase = PH_DONE;
                    r = tag_event(KIND_NO_HEADER);
                    return 1'b1;
                end
                step_cnt++;
                if (step_cnt >= MARKER_BYTES)
                begin
                    cur_phase = PH_SKIP;
                    step_cnt = '0;
                end
            end
            PH_SKIP:
            begin
                step_cnt++;
                if (step_cnt >= SKIP_BYTES)
                begin
                    cur_phase = PH_SIZE;
                    step_cnt = '0;
                end
            end
            PH_SIZE:
            begin
                // syncsafe: seven bits per byte, top bit dropped
                tag_len_bytes = {tag_len_bytes[20:0], b[6:0]};
                step_cnt++;
                if (step_cnt >= SIZE_BYTES)
                begin
                    cur_phase = PH_FHDR;
                    step_cnt = '0;
                    used_bytes = '0;
                end
            end
            PH_FHDR:
            begin
                // tag end is decided where a new frame header would begin
                if (step_cnt == 0 && (used_bytes >= {6'd0, tag_len_bytes} || b == 8'h00))
                begin
                    cur_phase = PH_DONE;
                    r = tag_event(KIND_TAG_DONE);
                    return 1'b1;
                end
                if (step_cnt < FRAME_ID_BYTES)
                    id_window = {id_window[23:0], b};
                else if (step_cnt < FRAME_LEN_END)
                    frame_len_bytes = {frame_len_bytes[23:0], b};
                step_cnt++;
                if (step_cnt >= FRAME_HDR_BYTES)
                begin
                    cur_field = text_field_of(id_window);
                    text_done = 1'b0;
                    payload_left = frame_len_bytes;
                    used_bytes = used_bytes + {30'd0, FRAME_HDR_BYTES}
                                 + {2'b00, frame_len_bytes};
                    step_cnt = '0;
                    if (frame_len_bytes == 0)
                    begin
                        if (cur_field != NO_FIELD)
                        begin
                            r.kind = KIND_FIELD_END;
                            r.field = cur_field;
                            has = 1'b1;
                        end
                        return has;
                    end
                    cur_phase = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD:
            begin
                enc = (step_cnt == 0);
                payload_left = payload_left - 32'd1;
                step_cnt = 4'd1;
                if (cur_field != NO_FIELD && !text_done)
                begin
                    if (enc)
                    begin
                        // frame holding only its encoding byte
                        if (payload_left == 0)
                        begin
                            text_done = 1'b1;
                            r.kind = KIND_FIELD_END;
                            r.field = cur_field;
                            has = 1'b1;
                        end
                    end
                    else if (b == 8'h00)
                    begin
                        text_done = 1'b1;
                        r.kind = KIND_FIELD_END;
                        r.field = cur_field;
                        has = 1'b1;
                    end
                    else
                    begin
                        r.kind = KIND_TEXT;
                        r.field = cur_field;
                        r.text_byte = b;
                        r.last = (payload_left == 0);
                        has = 1'b1;
                    end
                end
                if (payload_left == 0)
                begin
                    cur_phase = PH_FHDR;
                    step_cnt = '0;
                end
            end
            default:
                cur_phase = PH_DONE;
        endcase
        return has;
    endfunction

    // compare one result request with the oldest expectation
    task automatic check_result(input result_t got);
        result_t want;
        kind_seen[got.kind]++;
        if (owed_results.size() == 0)
        begin
            flag_error($sformatf("unexpected result kind %0d field %0d byte %02h last %0d",
                                 got.kind, got.field, got.text_byte, got.last));
            return;
        end
        want = owed_results.pop_front();
        if (got.kind != want.kind)
            flag_error($sformatf("kind got %0d want %0d", got.kind, want.kind));
        if (got.field != want.field)
            flag_error($sformatf("field got %0d want %0d", got.field, want.field));
        if (got.text_byte != want.text_byte)
            flag_error($sformatf("text_byte got %02h want %02h", got.text_byte, want.text_byte));
        if (got.last != want.last)
            flag_error($sformatf("last got %0d want %0d", got.last, want.last));
    endtask

    // monitor: results first, then predict from the byte taken at this edge
    always @(posedge clk)
    begin
        result_t got;
        result_t pred;
        bit      has;
        if (rst_n)
        begin
            if (text_if.valid && text_if.ready)
            begin
                got.kind = text_if.kind;
                got.field = text_if.field;
                got.text_byte = text_if.text_byte;
                got.last = text_if.last;
                check_result(got);
            end
            if (byte_if.valid && byte_if.ready)
            begin
                has = parse_byte(byte_if.start_of_file, byte_if.data_byte, pred);
                if (cur_typed)
                begin
                    if (cur_typed_has)
                        owed_results.push_back(cur_typed_res);
                end
                else if (has)
                    owed_results.push_back(pred);
            end
        end
    end

    // watchdog on cycles with no request moving on either side
    always @(posedge clk)
    begin
        if ((byte_if.valid && byte_if.ready) || (text_if.valid && text_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("watchdog: no request for %0d cycles, %0d results owed",
                     quiet_cycles, owed_results.size());
            $display("FAIL");
            $finish;
        end
    end

    // receiver stalls
    always @(negedge clk)
    begin
        if (rst_n)
            text_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // one byte request, with random gaps before it
    task automatic send_byte(input bit sof, input logic [7:0] b, input bit typed,
                             input bit typed_has, input result_t typed_res);
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            byte_if.valid <= 1'b0;
        end
        @(negedge clk);
        byte_if.valid <= 1'b1;
        byte_if.start_of_file <= sof;
        byte_if.data_byte <= b;
        cur_typed <= typed;
        cur_typed_has <= typed_has;
        cur_typed_res <= typed_res;
        @(posedge clk);
        while (!byte_if.ready)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic add_row(input bit sof, input logic [7:0] data, input bit typed,
                           input bit typed_has, input result_t typed_res);
        table_row_t row;
        row.sof = sof;
        row.data = data;
        row.typed = typed;
        row.typed_has = typed_has;
        row.typed_res = typed_res;
        byte_table.push_back(row);
    endtask

    function automatic logic [31:0] pick_text_id(input int i);
        logic [31:0] id;
        case (i)
            0:       id = ID_TIT2;
            1:       id = ID_TPE1;
            2:       id = ID_TALB;
            3:       id = ID_TYER;
            4:       id = ID_TCON;
            default: id = ID_TCOM;
        endcase
        return id;
    endfunction

    // build one random file into file_bytes, counted excludes bytes after the tag end
    task automatic build_file(output int counted);
        int          r;
        int          m;
        int          nfr;
        int          sel;
        int          k;
        int          j;
        int          cut;
        int          base;
        logic [31:0] id;
        logic [31:0] fsize;
        logic [31:0] total;
        logic [27:0] tsize;
        logic [7:0]  frames[$];
        bit          open_end;
        file_bytes.delete();
        r = $urandom_range(99);
        // plain noise, sometimes starting like a marker
        if (r < 6)
        begin
            k = $urandom_range(1, 12);
            for (j = 0; j < k; j++)
                file_bytes.push_back(8'($urandom_range(255)));
            if ($urandom_range(1))
                file_bytes[0] = ID3_MARK[23:16];
            counted = k;
            return;
        end
        file_bytes.push_back(ID3_MARK[23:16]);
        file_bytes.push_back(ID3_MARK[15:8]);
        file_bytes.push_back(ID3_MARK[7:0]);
        // broken marker at a random position
        if (r < 12)
        begin
            j = $urandom_range(2);
            file_bytes[j] = file_bytes[j] ^ 8'($urandom_range(1, 255));
        end
        for (j = 0; j < 3; j++)
            file_bytes.push_back(8'($urandom_range(255)));
        // frames
        total = '0;
        open_end = 1'b0;
        nfr = $urandom_range(0, 5);
        for (k = 0; k < nfr && !open_end; k++)
        begin
            sel = $urandom_range(99);
            if (sel < 70)
                id = pick_text_id($urandom_range(5));
            else if (sel < 85)
                id = pick_text_id($urandom_range(5)) ^ (32'h1 << $urandom_range(31));
            else
                id = {8'($urandom_range(1, 255)), 24'($urandom)};
            sel = $urandom_range(99);
            if (sel < 10)
                fsize = 0;
            else if (sel < 20)
                fsize = 1;
            else if (sel < 93)
                fsize = $urandom_range(2, 14);
            else
            begin
                fsize = $urandom | 32'h0100_0000;
                open_end = 1'b1;
            end
            for (j = 3; j >= 0; j--)
                frames.push_back(id[8 * j +: 8]);
            for (j = 3; j >= 0; j--)
                frames.push_back(fsize[8 * j +: 8]);
            frames.push_back(8'($urandom_range(255)));
            frames.push_back(8'($urandom_range(255)));
            // a huge frame is cut short by the next file
            if (open_end)
            begin
                j = $urandom_range(1, 16);
                while (j-- > 0)
                    frames.push_back(8'($urandom_range(255)));
            end
            else
            begin
                base = frames.size();
                sel = $urandom_range(99);
                for (j = 0; j < fsize; j++)
                begin
                    if (j == 0 || sel < 10)
                        frames.push_back(8'($urandom_range(255)));
                    else
                        frames.push_back(8'($urandom_range(1, 255)));
                end
                if (sel >= 10 && sel < 45 && fsize > 1)
                    frames[base + $urandom_range(1, fsize - 1)] = 8'h00;
                total = total + 10 + fsize;
            end
        end
        // tag size: exact, zero, short of the frames, or large
        m = $urandom_range(99);
        if (m < 45)
            tsize = total[27:0];
        else if (m < 60)
            tsize = '0;
        else if (m < 75)
            tsize = 28'($urandom_range(0, total));
        else if (m < 85)
            tsize = 28'h0FF_FFFF;
        else
            tsize = 28'($urandom);
        for (j = 3; j >= 0; j--)
            file_bytes.push_back({1'($urandom_range(1)), tsize[7 * j +: 7]});
        foreach (frames[j])
            file_bytes.push_back(frames[j]);
        if (!open_end)
        begin
            if (m < 75)
                file_bytes.push_back(8'($urandom_range(255)));
            else if ($urandom_range(99) < 85)
                file_bytes.push_back(8'h00);
        end
        counted = file_bytes.size();
        // bytes past the tag end
        j = $urandom_range(0, 3);
        while (j-- > 0)
            file_bytes.push_back(8'($urandom_range(255)));
        // truncated file
        if ($urandom_range(99) < 8)
        begin
            cut = $urandom_range(1, file_bytes.size());
            while (file_bytes.size() > cut)
                void'(file_bytes.pop_back());
            if (counted > cut)
                counted = cut;
        end
    endtask

    // stimulus
    initial
    begin
        int      useful;
        int      n;
        int      i;
        result_t none;
        none = '0;
        rst_n = 1'b0;
        byte_if.valid = 1'b0;
        byte_if.start_of_file = 1'b0;
        byte_if.data_byte = 8'h00;
        text_if.ready = 1'b0;
        cur_typed = 1'b0;
        cur_typed_has = 1'b0;
        cur_typed_res = '0;
        restart_parser();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // bad marker on the second byte, then a byte that is dropped
        add_row(1'b1, 8'h49, 1'b0, 1'b0, none);
        add_row(1'b0, 8'h58, 1'b1, 1'b1, tag_event(KIND_NO_HEADER));
        add_row(1'b0, 8'h00, 1'b1, 1'b0, none);
        // good header, extreme skip bytes, size bytes with the top bit set (size 11)
        add_row(1'b1, 8'h49, 1'b0, 1'b0, none);
        add_row(1'b0, 8'h44, 1'b0, 1'b0, none);
        add_row(1'b0, 8'h33, 1'b0, 1'b0, none);
        add_row(1'b0, 8'hff, 1'b0, 1'b0, none);
        add_row(1'b0, 8'hff, 1'b0, 1'b0, none);
        add_row(1'b0, 8'h00, 1'b0, 1'b0, none);
        add_row(1'b0, 8'h80, 1'b0, 1'b0, none);
        add_row(1'b0, 8'h80, 1'b0, 1'b0, none);
        add_row(1'b0, 8'h80, 1'b0, 1'b0, none);
        add_row(1'b0, 8'h8b, 1'b0, 1'b0, none);
        // artist frame holding only its encoding byte
        for (i = 3; i >= 0; i--)
            add_row(1'b0, ID_TPE1[8 * i +: 8], 1'b0, 1'b0, none);
        add_row(1'b0, 8'h00, 1'b0, 1'b0, none);
        add_row(1'b0, 8'h00, 1'b0, 1'b0, none);
        add_row(1'b0, 8'h00, 1'b0, 1'b0, none);
        add_row(1'b0, 8'h01, 1'b0, 1'b0, none);
        add_row(1'b0, 8'hff, 1'b0, 1'b0, none);
        add_row(1'b0, 8'hff, 1'b0, 1'b0, none);
        add_row(1'b0, 8'hff, 1'b0, 1'b0, none);
        // size used up: tag done on the next header byte, then dropped bytes
        add_row(1'b0, 8'h54, 1'b1, 1'b1, tag_event(KIND_TAG_DONE));
        add_row(1'b0, 8'h54, 1'b1, 1'b0, none);

        foreach (byte_table[i])
            send_byte(byte_table[i].sof, byte_table[i].data, byte_table[i].typed,
                      byte_table[i].typed_has, byte_table[i].typed_res);
        table_bytes = byte_table.size();
        files_sent = 2;

        // random tag files, idle pattern changes by thirds
        useful = 0;
        while (useful < RANDOM_ITEMS)
        begin
            if (useful >= 2 * RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            else if (useful >= RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 61;
                recv_idle_pct = 19;
            end
            build_file(n);
            foreach (file_bytes[i])
                send_byte(i == 0, file_bytes[i], 1'b0, 1'b0, none);
            useful += n;
            files_sent++;
        end
        @(negedge clk);
        byte_if.valid <= 1'b0;

        // drain, then wait for stray results
        while (owed_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("covered %0d files in %0d bytes, %0d of them from the directed table",
                 files_sent, bytes_sent, table_bytes);
        $display("results: %0d text, %0d field end, %0d tag done, %0d no header; %0d mismatches",
                 kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3], mismatches);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
